/* rtl/core/lz77_stream_decompressor_assert.svh */
// Assertion macros shared by the decompressor modules.
// Used inside modules that have clk_i and rst_ni in scope; needs no package.
`ifndef LZ77_STREAM_DECOMPRESSOR_ASSERT_SVH
`define LZ77_STREAM_DECOMPRESSOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked on every rising clock edge outside reset.
`define LZD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("decompressor assertion failed");
// Condition that must never hold outside reset.
`define LZD_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("decompressor forbidden condition seen");
`else
`define LZD_ASSERT(lbl, prop)
`define LZD_ASSERT_NEVER(lbl, cond)
`endif
`endif

/* rtl/core/lzd_pkg.sv */
// Shared types and constants of the LZ77 stream decompressor.
// Used by lzd_ctrl, lzd_datapath and the top level; depends on nothing.
package lzd_pkg;

  // Frame marker values and block format constants.
  localparam logic [7:0] MARK_RAW   = 8'h00;
  localparam logic [7:0] MARK_LZ    = 8'h01;
  localparam logic [7:0] LEN_CONT   = 8'hFF;
  localparam int unsigned MATCH_BIAS = 4;
  localparam int unsigned LEN_W      = 24;
  localparam int unsigned OUT_TDATA_W = 96;

  // Parse phase of the current frame.
  typedef enum logic [3:0] {
    PH_MARKER = 4'd0,
    PH_RAW    = 4'd1,
    PH_LITLEN = 4'd2,
    PH_LIT    = 4'd3,
    PH_OFFLO  = 4'd4,
    PH_OFFHI  = 4'd5,
    PH_MLEN   = 4'd6
  } phase_e;

  // Frame status codes.
  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_MARKER  = 3'd1,
    ERR_TRUNC   = 3'd2,
    ERR_BADOFF  = 3'd3,
    ERR_CAP     = 3'd4,
    ERR_TOOLONG = 3'd5,
    ERR_EMPTY   = 3'd6
  } err_e;

  // Flow controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_COPY = 1'b1
  } ctrl_state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic take;
    logic copy_run;
  } lzd_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic out_free;
    logic copy_start;
    logic copy_end;
  } lzd_status_t;

endpackage

/* rtl/core/lzd_ctrl.sv */
// Flow controller: takes input words while idle, runs match copies.
// Depends on lzd_pkg and the assertion macro header.
`include "lz77_stream_decompressor_assert.svh"
module lzd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  lzd_pkg::lzd_status_t status_i,
  output lzd_pkg::lzd_cmd_t    cmd_o
);
  import lzd_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = status_i.out_free;
        cmd_o.take = s_valid_i && status_i.out_free;
        if (cmd_o.take && status_i.copy_start) begin
          state_d = ST_COPY;
        end
      end
      ST_COPY: begin
        cmd_o.copy_run = 1'b1;
        if (status_i.copy_end) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `LZD_ASSERT(a_copy_entered, cmd_o.take && status_i.copy_start |=> state_q == ST_COPY)
  `LZD_ASSERT(a_no_input_in_copy, state_q == ST_COPY |-> !s_ready_o)
  `LZD_ASSERT(a_copy_left, state_q == ST_COPY && status_i.copy_end |=> state_q == ST_IDLE)

endmodule

/* rtl/core/lzd_datapath.sv */
// Datapath: frame parser registers, history memory, match copy and packer.
// Depends on lzd_pkg and the assertion macro header.
`include "lz77_stream_decompressor_assert.svh"
module lzd_datapath #(
  parameter int HISTORY_DEPTH    = 65536,
  parameter int MAX_MATCH_LEN    = 271,
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lzd_pkg::lzd_cmd_t    cmd_i,
  output lzd_pkg::lzd_status_t status_o,
  input  logic [7:0]           frame_byte_i,
  input  logic                 frame_last_i,
  input  logic                 cfg_we_i,
  input  logic [23:0]          cfg_wdata_i,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic [63:0]          out_bytes_o,
  output logic [3:0]           byte_count_o,
  output logic                 run_last_o,
  output logic                 frame_done_o,
  output logic [2:0]           error_code_o,
  output logic [23:0]          output_length_o
);
  import lzd_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(MAX_MATCH_LEN + 1);
  localparam int PW = 8 * BYTES_PER_RESULT;
  localparam logic [3:0] PK_FULL = 4'(BYTES_PER_RESULT);

  // Parser state.
  logic [23:0] cap_q;
  phase_e      ph_q, ph_d;
  logic [23:0] acc_q, acc_d;
  logic [23:0] litrem_q, litrem_d;
  logic        nolit_q, nolit_d;
  logic [7:0]  offlo_q, offlo_d;
  logic [15:0] moff_q, moff_d;
  logic [23:0] dec_q, dec_step;
  logic        closed_q, closed_d;
  logic [AW-1:0] ptr_q, ptr_step, ptr_inc;

  // Step decode results.
  logic        st_emit, st_done, st_copy;
  err_e        st_err;
  logic [24:0] len_sum, ml_sum;
  logic [15:0] off;

  // History memory and copy engine.
  logic [7:0]    mem [HISTORY_DEPTH];
  logic [7:0]    mem_rd_q, byp_data_q, rd_byte, wdata;
  logic          byp_q, we;
  logic          rd_vld_q;
  logic [AW-1:0] src_q, src_start, src_inc;
  logic [16:0]   src_diff;
  logic [CW-1:0] rd_left_q, wr_left_q;
  logic          pend_done_q;
  logic          out_free, pk_full, flush, consume, rd_adv, issue;

  // Packer and output register.
  logic [PW-1:0] pk_bytes_q, pk_base, pk_next;
  logic [3:0]    pk_cnt_q, pk_base_cnt;
  logic          m_valid_q, m_last_q, m_done_q;
  logic [63:0]   m_bytes_q;
  logic [3:0]    m_cnt_q;
  err_e          m_err_q;
  logic [23:0]   m_len_q;

  assign ptr_inc  = (ptr_q == AW'(HISTORY_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
  assign src_inc  = (src_q == AW'(HISTORY_DEPTH - 1)) ? '0 : src_q + 1'b1;
  assign src_diff = 17'(ptr_q) - {1'b0, moff_q};
  assign src_start = src_diff[16] ? AW'(src_diff + 17'(HISTORY_DEPTH)) : AW'(src_diff);

  // Decode of one input word against the parser state.
  always_comb begin
    ph_d     = ph_q;
    acc_d    = acc_q;
    litrem_d = litrem_q;
    nolit_d  = nolit_q;
    offlo_d  = offlo_q;
    moff_d   = moff_q;
    closed_d = closed_q;
    dec_step = dec_q;
    ptr_step = ptr_q;
    st_emit  = 1'b0;
    st_done  = 1'b0;
    st_copy  = 1'b0;
    st_err   = ERR_NONE;
    len_sum  = {1'b0, acc_q} + 25'(frame_byte_i);
    ml_sum   = len_sum + 25'(MATCH_BIAS);
    off      = {frame_byte_i, offlo_q};
    if (!closed_q) begin
      unique case (ph_q)
        PH_MARKER: begin
          acc_d    = '0;
          litrem_d = '0;
          nolit_d  = 1'b0;
          offlo_d  = '0;
          moff_d   = '0;
          dec_step = '0;
          ptr_step = '0;
          if (frame_byte_i == MARK_RAW) begin
            ph_d = PH_RAW;
          end else if (frame_byte_i == MARK_LZ) begin
            ph_d = PH_LITLEN;
          end else begin
            st_err = ERR_MARKER;
          end
        end
        PH_RAW: begin
          if ({1'b0, dec_q} + 25'd1 > {1'b0, cap_q}) begin
            st_err = ERR_CAP;
          end else begin
            st_emit = 1'b1;
          end
        end
        PH_LITLEN: begin
          acc_d = len_sum[23:0];
          if (len_sum[24]) begin
            st_err = ERR_CAP;
          end else if (frame_byte_i != LEN_CONT) begin
            acc_d   = '0;
            nolit_d = (len_sum == 25'd0);
            if (len_sum == 25'd0) begin
              ph_d = PH_OFFLO;
            end else if ({1'b0, dec_q} + len_sum > {1'b0, cap_q}) begin
              st_err = ERR_CAP;
            end else begin
              litrem_d = len_sum[23:0];
              ph_d     = PH_LIT;
            end
          end
        end
        PH_LIT: begin
          st_emit  = 1'b1;
          litrem_d = litrem_q - 24'd1;
          if (litrem_q == 24'd1) begin
            ph_d = PH_OFFLO;
          end
        end
        PH_OFFLO: begin
          offlo_d = frame_byte_i;
          ph_d    = PH_OFFHI;
        end
        PH_OFFHI: begin
          moff_d = off;
          if (off == 16'd0) begin
            // Empty block with no offset closes the frame.
            if (nolit_q) begin
              st_done = 1'b1;
              st_err  = (dec_q == 24'd0) ? ERR_EMPTY : ERR_NONE;
            end else begin
              ph_d = PH_LITLEN;
            end
          end else if (24'(off) > dec_q || 24'(off) > 24'(HISTORY_DEPTH)) begin
            st_err = ERR_BADOFF;
          end else begin
            acc_d = '0;
            ph_d  = PH_MLEN;
          end
        end
        PH_MLEN: begin
          acc_d = len_sum[23:0];
          if (ml_sum > 25'(MAX_MATCH_LEN)) begin
            st_err = ERR_TOOLONG;
          end else if (frame_byte_i != LEN_CONT) begin
            acc_d = '0;
            if ({1'b0, dec_q} + ml_sum > {1'b0, cap_q}) begin
              st_err = ERR_CAP;
            end else begin
              st_copy = 1'b1;
              ph_d    = PH_LITLEN;
            end
          end
        end
        default: begin
          ph_d = PH_MARKER;
        end
      endcase
      if (st_emit) begin
        dec_step = dec_q + 24'd1;
        ptr_step = ptr_inc;
      end
      if (st_err != ERR_NONE) begin
        st_done = 1'b1;
      end
      // Frame end outside a block boundary is a truncation.
      if (!st_done && frame_last_i) begin
        st_done = 1'b1;
        if (ph_d == PH_RAW || (ph_d == PH_LITLEN && acc_d == 24'd0)) begin
          st_err = (dec_step == 24'd0 && !st_copy) ? ERR_EMPTY : ERR_NONE;
        end else begin
          st_err = ERR_TRUNC;
        end
      end
      if (st_done) begin
        closed_d = 1'b1;
      end
    end
    if (frame_last_i) begin
      ph_d     = PH_MARKER;
      closed_d = 1'b0;
    end
  end

  // Copy engine handshaking between read port, packer and output register.
  assign out_free = !m_valid_q || m_ready_i;
  assign pk_full  = (pk_cnt_q == PK_FULL);
  assign flush    = cmd_i.copy_run && out_free && (pk_cnt_q != 4'd0) &&
                    (pk_full || wr_left_q == '0);
  assign consume  = cmd_i.copy_run && rd_vld_q && (!pk_full || flush);
  assign rd_adv   = cmd_i.copy_run && (!rd_vld_q || consume);
  assign issue    = rd_adv && (rd_left_q != '0);
  assign rd_byte  = byp_q ? byp_data_q : mem_rd_q;

  assign we    = (cmd_i.take && st_emit) || consume;
  assign wdata = cmd_i.take ? frame_byte_i : rd_byte;

  // Next packer contents with the copied byte in its lane.
  always_comb begin
    pk_base     = flush ? '0 : pk_bytes_q;
    pk_base_cnt = flush ? 4'd0 : pk_cnt_q;
    pk_next     = pk_base;
    for (int i = 0; i < BYTES_PER_RESULT; i++) begin
      if (4'(i) == pk_base_cnt) begin
        pk_next[8*i +: 8] = rd_byte;
      end
    end
  end

  assign status_o.out_free   = out_free;
  assign status_o.copy_start = st_copy;
  assign status_o.copy_end   = cmd_i.copy_run && (wr_left_q == '0) && (pk_cnt_q == 4'd0);

  // History memory with a bypass for a read of the entry written in the same cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[ptr_q] <= wdata;
    end
    if (issue) begin
      mem_rd_q   <= mem[src_q];
      byp_q      <= we && (ptr_q == src_q);
      byp_data_q <= wdata;
    end
  end

  // Parser and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= 24'hFFFFFF;
      ph_q     <= PH_MARKER;
      acc_q    <= '0;
      litrem_q <= '0;
      nolit_q  <= 1'b0;
      offlo_q  <= '0;
      moff_q   <= '0;
      dec_q    <= '0;
      closed_q <= 1'b0;
      ptr_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.take) begin
        ph_q     <= ph_d;
        acc_q    <= acc_d;
        litrem_q <= litrem_d;
        nolit_q  <= nolit_d;
        offlo_q  <= offlo_d;
        moff_q   <= moff_d;
        closed_q <= closed_d;
        dec_q    <= dec_step;
        ptr_q    <= ptr_step;
      end else if (consume) begin
        dec_q <= dec_q + 24'd1;
        ptr_q <= ptr_inc;
      end
    end
  end

  // Copy counters and packer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      src_q       <= '0;
      rd_left_q   <= '0;
      wr_left_q   <= '0;
      pend_done_q <= 1'b0;
      pk_cnt_q    <= '0;
    end else if (cmd_i.take && st_copy) begin
      rd_vld_q    <= 1'b0;
      src_q       <= src_start;
      rd_left_q   <= CW'(ml_sum);
      wr_left_q   <= CW'(ml_sum);
      pend_done_q <= st_done;
      pk_cnt_q    <= '0;
    end else begin
      if (rd_adv) begin
        rd_vld_q <= issue;
      end
      if (issue) begin
        src_q     <= src_inc;
        rd_left_q <= rd_left_q - 1'b1;
      end
      if (consume) begin
        wr_left_q <= wr_left_q - 1'b1;
        pk_cnt_q  <= pk_base_cnt + 4'd1;
      end else if (flush) begin
        pk_cnt_q <= '0;
      end
    end
  end

  // Packer data needs no reset; it is cleared when a copy starts.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && st_copy) begin
      pk_bytes_q <= '0;
    end else if (consume || flush) begin
      pk_bytes_q <= consume ? pk_next : '0;
    end
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_last_q  <= 1'b0;
      m_done_q  <= 1'b0;
    end else if (cmd_i.take && (st_emit || st_done) && !st_copy) begin
      m_valid_q <= 1'b1;
      m_last_q  <= 1'b1;
      m_done_q  <= st_done;
    end else if (flush) begin
      m_valid_q <= 1'b1;
      m_last_q  <= (wr_left_q == '0);
      m_done_q  <= pend_done_q && (wr_left_q == '0);
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && (st_emit || st_done) && !st_copy) begin
      m_bytes_q <= st_emit ? 64'(frame_byte_i) : 64'd0;
      m_cnt_q   <= st_emit ? 4'd1 : 4'd0;
      m_err_q   <= st_done ? st_err : ERR_NONE;
      m_len_q   <= st_done ? dec_step : 24'd0;
    end else if (flush) begin
      m_bytes_q <= 64'(pk_bytes_q);
      m_cnt_q   <= pk_cnt_q;
      m_err_q   <= ERR_NONE;
      m_len_q   <= (pend_done_q && wr_left_q == '0) ? dec_q : 24'd0;
    end
  end

  assign m_valid_o       = m_valid_q;
  assign out_bytes_o     = m_bytes_q;
  assign byte_count_o    = m_cnt_q;
  assign run_last_o      = m_last_q;
  assign frame_done_o    = m_done_q;
  assign error_code_o    = m_err_q;
  assign output_length_o = m_len_q;

  `LZD_ASSERT(a_pk_bound, pk_cnt_q <= PK_FULL)
  `LZD_ASSERT(a_read_has_slot, rd_vld_q |-> wr_left_q != '0)
  `LZD_ASSERT(a_done_on_last, m_valid_q && m_done_q |-> m_last_q)
  `LZD_ASSERT_NEVER(a_take_not_in_copy, cmd_i.take && cmd_i.copy_run)

endmodule

/* rtl/core/lz77_stream_decompressor.sv */
// Channel  | handshake                   | payload
// s_axis   | s_axis_tvalid/s_axis_tready | tdata[7:0] frame byte, tlast frame end
// m_axis   | m_axis_tvalid/m_axis_tready | tdata bytes/count/length, tlast, tuser
// cfg      | cfg_valid_i/cfg_ready_o     | cfg_wdata_i output capacity
// Marker, raw, literal and header bytes are taken back to back while the output register is free.
// A byte that completes a match length starts a copy of L bytes; input is held off after that word
// until the copy is packed and flushed, one byte per cycle through the single history read port.
// Output stalls hold the copy; no input word is taken during a copy.
// Reset clears control state only; history is not cleared and needs no sweep.
// Top level of the LZ77 stream decompressor; depends on lzd_pkg, lzd_ctrl, lzd_datapath.
module lz77_stream_decompressor #(
  parameter int HISTORY_DEPTH    = 65536,
  parameter int MAX_MATCH_LEN    = 271,
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [7:0] frame_byte
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [63:0] out_bytes, [67:64] byte_count, [91:68] output_length, [95:92] zero
  output logic [lzd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast,
  output logic [3:0]                          m_axis_tuser,  // [0] frame_done, [3:1] error_code
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [23:0]                         cfg_wdata_i
);
  import lzd_pkg::*;

  lzd_cmd_t    cmd;
  lzd_status_t status;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic [2:0]  error_code;
  logic [23:0] output_length;
  logic        frame_done;

  assign cfg_ready_o = 1'b1;

  // Flow controller.
  lzd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Parser, history and packer.
  lzd_datapath #(
    .HISTORY_DEPTH    (HISTORY_DEPTH),
    .MAX_MATCH_LEN    (MAX_MATCH_LEN),
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .frame_byte_i    (s_axis_tdata),
    .frame_last_i    (s_axis_tlast),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_wdata_i     (cfg_wdata_i),
    .m_valid_o       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .out_bytes_o     (out_bytes),
    .byte_count_o    (byte_count),
    .run_last_o      (m_axis_tlast),
    .frame_done_o    (frame_done),
    .error_code_o    (error_code),
    .output_length_o (output_length)
  );

  // Output word packing.
  assign m_axis_tdata = {4'd0, output_length, byte_count, out_bytes};
  assign m_axis_tuser = {error_code, frame_done};

endmodule

/* test/tb_lz77_stream_decompressor.sv */
// Self-checking testbench for the LZ77 stream decompressor: drives framed byte streams,
// predicts the packed output words and compares them. Depends on lzd_pkg and the top level.
`timescale 1ns / 100ps

module tb_lz77_stream_decompressor;
  import lzd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned MASK24 = 24'hFFFFFF;

  // One decoded output word as the block presents it.
  typedef struct {
    logic [63:0] bytes;
    logic [3:0]  cnt;
    logic        run_last;
    logic        done;
    logic [2:0]  err;
    logic [23:0] len;
  } out_word_t;

  // Frame decoder prediction plus the queue of words still owed by the block.
  class lz_scoreboard;
    int unsigned capacity;
    phase_e      phase;
    int unsigned len_acc, lit_left, no_lit, off_lo, offset, decoded;
    bit          closed;
    logic [7:0]  hist [65536];
    out_word_t   owed [$];
    out_word_t   step_words [$];
    logic [63:0] pack;
    int          pack_n;
    int          fails;

    function new();
      capacity = MASK24;
      fails = 0;
      restart();
    endfunction

    function void restart();
      phase = PH_MARKER;
      len_acc = 0;
      lit_left = 0;
      no_lit = 0;
      off_lo = 0;
      offset = 0;
      decoded = 0;
      closed = 0;
    endfunction

    // Store one decoded byte in history and pack it.
    function void put_byte(logic [7:0] b);
      out_word_t w;
      hist[decoded % 65536] = b;
      decoded = (decoded + 1) & MASK24;
      pack |= 64'(b) << (8 * pack_n);
      pack_n++;
      if (pack_n >= 8) begin
        w.bytes = pack;
        w.cnt = 4'd8;
        w.run_last = 0;
        w.done = 0;
        w.err = ERR_NONE;
        w.len = '0;
        step_words.push_back(w);
        pack = '0;
        pack_n = 0;
      end
    endfunction

    // Work out the words that one accepted input byte causes.
    function void note_byte(logic [7:0] b, bit last);
      logic [2:0]  err;
      bit          done;
      int unsigned n;
      int unsigned i;
      out_word_t   w;
      err = ERR_NONE;
      done = 0;
      if (closed) begin
        if (last) restart();
        return;
      end
      pack = '0;
      pack_n = 0;
      step_words.delete();
      case (phase)
        PH_MARKER: begin
          restart();
          if (b == MARK_RAW) phase = PH_RAW;
          else if (b == MARK_LZ) phase = PH_LITLEN;
          else err = ERR_MARKER;
        end
        PH_RAW: begin
          if (decoded + 1 > capacity) err = ERR_CAP;
          else put_byte(b);
        end
        PH_LITLEN: begin
          len_acc += b;
          if (len_acc > MASK24) begin
            err = ERR_CAP;
          end else if (b != LEN_CONT) begin
            n = len_acc;
            len_acc = 0;
            no_lit = (n == 0);
            if (n == 0) phase = PH_OFFLO;
            else if (decoded + n > capacity) err = ERR_CAP;
            else begin
              lit_left = n;
              phase = PH_LIT;
            end
          end
        end
        PH_LIT: begin
          put_byte(b);
          lit_left = (lit_left - 1) & MASK24;
          if (lit_left == 0) phase = PH_OFFLO;
        end
        PH_OFFLO: begin
          off_lo = b;
          phase = PH_OFFHI;
        end
        PH_OFFHI: begin
          offset = off_lo | (int'(b) << 8);
          if (offset == 0) begin
            if (no_lit) begin
              done = 1;
              err = (decoded == 0) ? ERR_EMPTY : ERR_NONE;
            end else phase = PH_LITLEN;
          end else if (offset > decoded || offset > 65536) err = ERR_BADOFF;
          else begin
            len_acc = 0;
            phase = PH_MLEN;
          end
        end
        PH_MLEN: begin
          len_acc += b;
          if (len_acc + MATCH_BIAS > 271) begin
            err = ERR_TOOLONG;
          end else if (b != LEN_CONT) begin
            n = len_acc + MATCH_BIAS;
            len_acc = 0;
            if (decoded + n > capacity) err = ERR_CAP;
            else begin
              // Overlapping copies read bytes written earlier in this same loop.
              for (i = 0; i < n; i++) put_byte(hist[(decoded - offset) % 65536]);
              phase = PH_LITLEN;
            end
          end
        end
        default: phase = PH_MARKER;
      endcase

      if (err != ERR_NONE) done = 1;
      if (!done && last) begin
        done = 1;
        if (phase == PH_RAW || (phase == PH_LITLEN && len_acc == 0))
          err = (decoded == 0) ? ERR_EMPTY : ERR_NONE;
        else err = ERR_TRUNC;
      end

      // The frame status rides on the last data word, or on a word of its own.
      if (pack_n > 0 || (done && step_words.size() == 0)) begin
        w.bytes = pack;
        w.cnt = 4'(pack_n);
        w.run_last = 0;
        w.done = done;
        w.err = done ? err : ERR_NONE;
        w.len = done ? 24'(decoded) : '0;
        step_words.push_back(w);
      end else if (done) begin
        step_words[step_words.size() - 1].done = 1;
        step_words[step_words.size() - 1].err = err;
        step_words[step_words.size() - 1].len = 24'(decoded);
      end
      if (step_words.size() > 0) step_words[step_words.size() - 1].run_last = 1;
      foreach (step_words[k]) owed.push_back(step_words[k]);

      if (done) closed = 1;
      if (last) restart();
    endfunction

    // Compare one accepted output word with the oldest owed word.
    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (owed.size() == 0) begin
        $display("%0t: unexpected word bytes=%h cnt=%0d", $time, got.bytes, got.cnt);
        fails++;
        return;
      end
      exp_w = owed.pop_front();
      if (got.bytes !== exp_w.bytes) begin
        $display("%0t: out_bytes expected %h actual %h", $time, exp_w.bytes, got.bytes);
        fails++;
      end
      if (got.cnt !== exp_w.cnt) begin
        $display("%0t: byte_count expected %0d actual %0d", $time, exp_w.cnt, got.cnt);
        fails++;
      end
      if (got.run_last !== exp_w.run_last) begin
        $display("%0t: run_last expected %0d actual %0d", $time, exp_w.run_last,
                 got.run_last);
        fails++;
      end
      if (got.done !== exp_w.done) begin
        $display("%0t: frame_done expected %0d actual %0d", $time, exp_w.done, got.done);
        fails++;
      end
      if (got.err !== exp_w.err) begin
        $display("%0t: error_code expected %0d actual %0d", $time, exp_w.err, got.err);
        fails++;
      end
      if (got.len !== exp_w.len) begin
        $display("%0t: output_length expected %0d actual %0d", $time, exp_w.len, got.len);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [3:0]  m_axis_tuser;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [23:0] cfg_wdata_i = '0;

  lz_scoreboard sb = new();
  bit          in_taken, cfg_taken;
  bit          quiet_tx, quiet_rx;
  int unsigned hold_left;
  int unsigned cycles;
  int unsigned sent;

  lz77_stream_decompressor i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver readiness, with random stalls and an optional long hold-off.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= quiet_rx || ($urandom_range(0, 99) >= 9);
    end
  end

  // Handshakes are sampled mid-cycle, once all inputs have settled.
  always @(negedge clk_i) begin
    out_word_t w;
    in_taken = s_axis_tvalid && s_axis_tready;
    cfg_taken = cfg_valid_i && cfg_ready_o;
    if (in_taken) sb.note_byte(s_axis_tdata, s_axis_tlast);
    if (cfg_taken) sb.capacity = cfg_wdata_i;
    if (m_axis_tvalid && m_axis_tready) begin
      w.bytes = m_axis_tdata[63:0];
      w.cnt = m_axis_tdata[67:64];
      w.len = m_axis_tdata[91:68];
      w.run_last = m_axis_tlast;
      w.done = m_axis_tuser[0];
      w.err = m_axis_tuser[3:1];
      sb.check_word(w);
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit last);
    if (!quiet_tx && $urandom_range(0, 99) < 9) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!in_taken);
    sent++;
  endtask

  task automatic send_frame(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // Let every owed word arrive, then give a copy in flight time to finish.
  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [23:0] cap);
    cfg_valid_i <= 1;
    cfg_wdata_i <= cap;
    do @(posedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 0;
  endtask

  // 255-continued length field.
  function automatic void push_len(ref logic [7:0] q[$], input int unsigned n);
    while (n >= 255) begin
      q.push_back(LEN_CONT);
      n -= 255;
    end
    q.push_back(8'(n));
  endfunction

  // Well-formed compressed frame with random content, sometimes broken or noisy.
  function automatic void build_lz_frame(ref logic [7:0] q[$]);
    int unsigned blocks, lit, off, mlen, total;
    q = {MARK_LZ};
    total = 0;
    blocks = $urandom_range(1, 3);
    for (int k = 0; k < blocks; k++) begin
      lit = ($urandom_range(0, 29) == 0) ? $urandom_range(255, 262) : $urandom_range(0, 12);
      if (total == 0 && lit == 0) lit = 1;
      push_len(q, lit);
      repeat (lit) q.push_back(8'($urandom));
      total += lit;
      off = $urandom_range(1, (total > 65535) ? 65535 : total);
      if ($urandom_range(0, 19) == 0) off = total + 1;
      q.push_back(8'(off));
      q.push_back(8'(off >> 8));
      mlen = ($urandom_range(0, 7) == 0) ? $urandom_range(259, 272) : $urandom_range(4, 20);
      push_len(q, mlen - MATCH_BIAS);
      total += mlen;
    end
    if ($urandom_range(0, 1)) begin
      q.push_back(8'h00);
      q.push_back(8'h00);
      q.push_back(8'h00);
      repeat ($urandom_range(0, 2)) q.push_back(8'($urandom));
    end
    if ($urandom_range(0, 9) == 0) q = q[0:$urandom_range(0, q.size() - 1)];
  endfunction

  task automatic random_frames(input int unsigned target);
    logic [7:0] q[$];
    int unsigned stop;
    stop = sent + target;
    while (sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          q = {MARK_RAW};
          repeat ($urandom_range(0, 20)) q.push_back(8'($urandom));
        end
        2: begin
          q = {};
          repeat ($urandom_range(1, 8)) q.push_back(8'($urandom));
        end
        default: build_lz_frame(q);
      endcase
      send_frame(q);
    end
  endtask

  initial begin
    quiet_tx = 0;
    quiet_rx = 0;
    hold_left = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Zero capacity: even a raw byte overflows.
    write_capacity(24'h000000);
    send_frame({MARK_RAW, 8'h5A, 8'hA5});
    drain();
    write_capacity(24'hFFFFFF);

    // Directed frames: raw extremes, marker only, bad marker, longest overlapping
    // match with end marker and trailing junk, too long match, bad offset, truncation.
    send_frame({MARK_RAW, 8'h00, 8'hFF});
    send_frame({MARK_LZ});
    send_frame({8'h07});
    send_frame({MARK_LZ, 8'h01, 8'hAA, 8'h01, 8'h00, LEN_CONT, 8'h0C,
                8'h00, 8'h00, 8'h00, 8'h3C});
    send_frame({MARK_LZ, 8'h01, 8'hBB, 8'h01, 8'h00, LEN_CONT, 8'h0D, 8'h00});
    send_frame({MARK_LZ, 8'h00, 8'h01, 8'h00});
    send_frame({MARK_LZ, 8'h03, 8'hAA});
    drain();

    // Long receiver hold-off while the sender keeps going, then a quiet stretch.
    hold_left = 400;
    random_frames(25);
    quiet_tx = 1;
    quiet_rx = 1;
    random_frames(25);
    quiet_tx = 0;
    quiet_rx = 0;
    drain();

    // Small capacity: capacity errors in mid frame.
    write_capacity(24'($urandom_range(5, 60)));
    random_frames(35);
    drain();
    write_capacity(24'hFFFFFF);
    random_frames(45);
    drain();

    if (sb.fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
